// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Opcodes, status codes, queue sizing and the structs that pass between the
// cells of the chain and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned Depth    = 16;
  localparam int unsigned TagBits  = 8;
  localparam int unsigned PrioBits = 16;
  localparam int unsigned CntW     = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Entry contents handed between neighbors.
  typedef struct packed {
    logic [PrioBits-1:0] prio;
    logic [TagBits-1:0]  tag;
  } entry_t;

  // Command broadcast to every cell; the action bits are already qualified.
  typedef struct packed {
    logic                push;
    logic                pop;
    logic                del;
    logic [PrioBits-1:0] prio;
    logic [TagBits-1:0]  tag;
  } ctl_t;

endpackage

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted priority queue chain
// Holds one entry and picks its next value from itself, the new request or
// one of its two neighbors.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic            clk_i,
  input  logic            valid_i,     // slot lies below the fill count
  input  spq_pkg::ctl_t   ctl_i,
  input  logic            left_le_i,   // upstream entry goes before the new one
  input  spq_pkg::entry_t left_i,
  input  spq_pkg::entry_t right_i,
  input  logic            seen_i,      // a tag match lies upstream
  output logic            le_o,
  output logic            seen_o,
  output logic            first_o,     // this slot is the first tag match
  output spq_pkg::entry_t entry_o
);

  spq_pkg::entry_t entry_q, entry_d;
  logic            match;

  assign le_o    = valid_i && (entry_q.prio <= ctl_i.prio);
  assign match   = valid_i && (entry_q.tag == ctl_i.tag);
  assign first_o = match && !seen_i;
  assign seen_o  = seen_i || match;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.push && !le_o) begin
      if (left_le_i) begin
        entry_d.prio = ctl_i.prio;
        entry_d.tag  = ctl_i.tag;
      end else begin
        entry_d = left_i;
      end
    end else if (ctl_i.pop || (ctl_i.del && seen_o)) begin
      // close the gap: advance the downstream entry
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== rtl/sorted_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_top: bounded priority queue kept in sorted order
// A chain of identical cells holds the entries sorted by ascending priority.
// ----------------------------------------------------------------------------
// Usage: each request carries an opcode (push, pop head, delete by tag, clear)
// with a priority and a tag. Entries stay sorted by ascending priority number,
// ties in arrival order. Every cell compares its entry with the request in
// parallel and takes its next value from itself, the request or a neighbor,
// so a request completes in the cycle it is accepted and its result appears
// in the output register on the next cycle: one request per cycle, limited by
// the compare and first-match chain across the Depth cells. A new request is
// taken whenever the output register is empty or is being drained in the same
// cycle. Every request returns exactly one result: the popped or deleted
// entry (zero otherwise), a status code and the occupancy after the request.
// Push into a full queue, pop from an empty one and delete of an absent tag
// leave the queue untouched and report status. Delete removes only the
// matching entry nearest the head. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] priority_req_i,
  input  logic [7:0]  tag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_priority_o,
  output logic [7:0]  out_tag_o,
  output logic [1:0]  status_o,
  output logic [4:0]  occupancy_o
);

  localparam int unsigned Depth = spq_pkg::Depth;
  localparam int unsigned CntW  = spq_pkg::CntW;

  // Fill count and output register.
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic                           out_valid_q;
  logic [spq_pkg::PrioBits-1:0]   res_prio_q, res_prio_d;
  logic [spq_pkg::TagBits-1:0]    res_tag_q, res_tag_d;
  spq_pkg::status_e               res_st_q, res_st_d;

  // Chain links.
  logic [Depth-1:0]               le;
  logic [Depth:0]                 seen;
  logic [Depth-1:0]               first;
  spq_pkg::entry_t [Depth-1:0]    entries;
  spq_pkg::entry_t                hit_entry;

  spq_pkg::ctl_t                  ctl;
  spq_pkg::op_e                   op;
  logic                           accept;
  logic                           full, empty, found;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign op         = spq_pkg::op_e'(op_i);
  assign full       = (cnt_q == CntW'(Depth));
  assign empty      = (cnt_q == '0);
  assign found      = seen[Depth];

  // Qualify the request before it reaches the cells: a refused request must
  // leave every cell untouched. A delete only moves cells at or behind a tag
  // match, so an absent tag leaves the chain as it is.
  always_comb begin
    ctl.prio = priority_req_i;
    ctl.tag  = tag_i[spq_pkg::TagBits-1:0];
    ctl.push = accept && (op == spq_pkg::OP_PUSH) && !full;
    ctl.pop  = accept && (op == spq_pkg::OP_POP) && !empty;
    ctl.del  = accept && (op == spq_pkg::OP_DELETE);
  end

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic            left_le;
    spq_pkg::entry_t left_e, right_e;

    if (i == 0) begin : g_head
      // the head has nothing ahead of it: a push that beats it lands here
      assign left_le = 1'b1;
      assign left_e  = entries[0];
    end else begin : g_body
      assign left_le = le[i-1];
      assign left_e  = entries[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign right_e = entries[i];
    end else begin : g_inner
      assign right_e = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i     (clk_i),
      .valid_i   (CntW'(i) < cnt_q),
      .ctl_i     (ctl),
      .left_le_i (left_le),
      .left_i    (left_e),
      .right_i   (right_e),
      .seen_i    (seen[i]),
      .le_o      (le[i]),
      .seen_o    (seen[i+1]),
      .first_o   (first[i]),
      .entry_o   (entries[i])
    );
  end

  // first is one-hot or zero: an OR of the gated entries selects the match
  always_comb begin
    hit_entry = '0;
    for (int unsigned k = 0; k < Depth; k++) begin
      hit_entry = hit_entry | (first[k] ? entries[k] : '0);
    end
  end

  // Decode the request into its result and the next fill count.
  always_comb begin
    cnt_d      = cnt_q;
    res_prio_d = '0;
    res_tag_d  = '0;
    res_st_d   = spq_pkg::ST_OK;
    unique case (op)
      spq_pkg::OP_PUSH: begin
        if (full) begin
          res_st_d = spq_pkg::ST_FULL;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      spq_pkg::OP_POP: begin
        if (empty) begin
          res_st_d = spq_pkg::ST_EMPTY;
        end else begin
          res_prio_d = entries[0].prio;
          res_tag_d  = entries[0].tag;
          cnt_d      = cnt_q - CntW'(1);
        end
      end
      spq_pkg::OP_DELETE: begin
        if (found) begin
          res_prio_d = hit_entry.prio;
          res_tag_d  = hit_entry.tag;
          cnt_d      = cnt_q - CntW'(1);
        end else begin
          res_st_d = spq_pkg::ST_NOTFOUND;
        end
      end
      spq_pkg::OP_CLEAR: begin
        cnt_d = '0;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q <= cnt_d;
      end
      // hold the result until taken; a new request refills in the same cycle
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_prio_q <= res_prio_d;
      res_tag_q  <= res_tag_d;
      res_st_q   <= res_st_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_priority_o = res_prio_q;
  assign out_tag_o      = 8'(res_tag_q);
  assign status_o       = res_st_q;
  assign occupancy_o    = 5'(cnt_q);

endmodule

// ===== rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker: port-level checks of the sorted priority queue
// Watches the result channel and flags results that contradict themselves.
// ----------------------------------------------------------------------------
module spq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] out_priority_o,
  input logic [7:0]  out_tag_o,
  input logic [1:0]  status_o,
  input logic [4:0]  occupancy_o
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_priority_o)
      && $stable(out_tag_o) && $stable(status_o) && $stable(occupancy_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == spq_pkg::ST_FULL |->
      occupancy_o == 5'(spq_pkg::Depth))
    else $error("full status with free slots");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == spq_pkg::ST_EMPTY |-> occupancy_o == 5'd0)
    else $error("empty status with entries held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == spq_pkg::ST_EMPTY || status_o == spq_pkg::ST_FULL
      || status_o == spq_pkg::ST_NOTFOUND) |-> out_priority_o == 16'd0
      && out_tag_o == 8'd0)
    else $error("failed request returned an entry");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_priority_o (out_priority_o),
  .out_tag_o      (out_tag_o),
  .status_o       (status_o),
  .occupancy_o    (occupancy_o)
);

// ===== bench/sorted_priority_queue_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_tb: self-checking bench for the sorted queue
// Drives push, pop, delete and clear requests with random gaps on both sides,
// keeps its own sorted copy of the queue to work out each result, and checks
// every result field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top_tb;

  localparam int Depth    = spq_pkg::Depth;
  localparam int PrioBits = spq_pkg::PrioBits;
  localparam int TagBits  = spq_pkg::TagBits;
  localparam int CntW     = spq_pkg::CntW;

  localparam int DrainLimit = 20000;   // cycles allowed for the last results
  localparam int TailCycles = 8;       // slack for a stray result after the drain
  localparam int TimeoutNs  = 2000000;

  // One predicted result, field for field as the block reports it.
  typedef struct {
    logic [PrioBits-1:0] prio;
    logic [TagBits-1:0]  tag;
    spq_pkg::status_e    st;
    logic [CntW-1:0]     occ;
  } queue_result_t;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  logic [1:0]    op_i;
  logic [15:0]   priority_req_i;
  logic [7:0]    tag_i;
  logic          out_valid_o;
  logic          out_ready_i;
  logic [15:0]   out_priority_o;
  logic [7:0]    out_tag_o;
  logic [1:0]    status_o;
  logic [4:0]    occupancy_o;

  // Shadow copy of the queue: slot 0 is the head, sorted by ascending priority.
  logic [PrioBits-1:0] held_prio [Depth];
  logic [TagBits-1:0]  held_tag  [Depth];
  int                  held_count;

  queue_result_t expected_q [$];

  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  int          err_count;
  int          checked_count;
  int          op_count     [4];
  int          status_count [4];

  sorted_priority_queue_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .priority_req_i (priority_req_i),
    .tag_i          (tag_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_priority_o (out_priority_o),
    .out_tag_o      (out_tag_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Queue predictor
  // --------------------------------------------------------------------------

  // Remove one slot and close the gap behind it.
  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < held_count; i++) begin
      held_prio[i] = held_prio[i+1];
      held_tag[i]  = held_tag[i+1];
    end
    held_count--;
  endfunction

  // Apply one request to the shadow queue and return what the block must report.
  function automatic queue_result_t apply_queue_op(spq_pkg::op_e op,
                                                   logic [PrioBits-1:0] p,
                                                   logic [TagBits-1:0] t);
    queue_result_t r;
    int            pos;
    int            hit;
    r.prio = '0;
    r.tag  = '0;
    r.st   = spq_pkg::ST_OK;
    case (op)
      spq_pkg::OP_PUSH: begin
        if (held_count >= Depth) begin
          r.st = spq_pkg::ST_FULL;
        end else begin
          // Go past every entry of equal or smaller number: ties stay in arrival order.
          pos = 0;
          while (pos < held_count && held_prio[pos] <= p) pos++;
          for (int i = held_count; i > pos; i--) begin
            held_prio[i] = held_prio[i-1];
            held_tag[i]  = held_tag[i-1];
          end
          held_prio[pos] = p;
          held_tag[pos]  = t;
          held_count++;
        end
      end
      spq_pkg::OP_POP: begin
        if (held_count == 0) begin
          r.st = spq_pkg::ST_EMPTY;
        end else begin
          r.prio = held_prio[0];
          r.tag  = held_tag[0];
          drop_entry(0);
        end
      end
      spq_pkg::OP_DELETE: begin
        // Only the matching entry nearest the head goes.
        hit = -1;
        for (int i = 0; i < held_count; i++) begin
          if (hit < 0 && held_tag[i] == t) hit = i;
        end
        if (hit < 0) begin
          r.st = spq_pkg::ST_NOTFOUND;
        end else begin
          r.prio = held_prio[hit];
          r.tag  = held_tag[hit];
          drop_entry(hit);
        end
      end
      default: begin
        held_count = 0;
      end
    endcase
    r.occ = CntW'(held_count);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: change inputs on the falling edge, look at the handshake on
  // the rising edge. Valid is written at most once per falling edge, and stays
  // high into the next request when there is no gap.
  // --------------------------------------------------------------------------
  task automatic send_request(spq_pkg::op_e op, logic [PrioBits-1:0] p,
                              logic [TagBits-1:0] t);
    queue_result_t res;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    op_i           = op;
    priority_req_i = p;
    tag_i          = t;
    do @(posedge clk_i); while (!in_ready_o);
    // Accepted at this edge: update the shadow queue in request order.
    res = apply_queue_op(op, p, t);
    expected_q.push_back(res);
    op_count[op]++;
    status_count[res.st]++;
    @(negedge clk_i);
  endtask

  // Stall the result side at random; the rate changes with the phase.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Result checker: compare every accepted result with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    queue_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("result with no request pending: prio %h tag %h status %0d occ %0d",
               out_priority_o, out_tag_o, status_o, occupancy_o);
        err_count++;
      end else begin
        want = expected_q.pop_front();
        checked_count++;
        if (out_priority_o !== want.prio) begin
          $error("out_priority: expected %h, got %h", want.prio, out_priority_o);
          err_count++;
        end
        if (out_tag_o !== want.tag) begin
          $error("out_tag: expected %h, got %h", want.tag, out_tag_o);
          err_count++;
        end
        if (status_o !== want.st) begin
          $error("status: expected %0d (%s), got %0d", want.st, want.st.name(), status_o);
          err_count++;
        end
        if (occupancy_o !== want.occ) begin
          $error("occupancy: expected %0d, got %0d", want.occ, occupancy_o);
          err_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Bias toward the extremes and a narrow band so ties are common.
  function automatic logic [PrioBits-1:0] pick_priority();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return PrioBits'($urandom_range(7));
      default: return PrioBits'($urandom);
    endcase
  endfunction

  // A few tags from a small set, so duplicated tags show up in the queue.
  function automatic logic [TagBits-1:0] pick_tag();
    if ($urandom_range(9) < 3) return TagBits'($urandom_range(3));
    return TagBits'($urandom);
  endfunction

  // Fill, drain and balanced modes move occupancy over its whole range.
  function automatic spq_pkg::op_e pick_op(int mode);
    int roll;
    int push_pct;
    int pop_pct;
    roll = $urandom_range(99);
    case (mode)
      0:       begin push_pct = 65; pop_pct = 15; end
      1:       begin push_pct = 20; pop_pct = 55; end
      default: begin push_pct = 45; pop_pct = 30; end
    endcase
    if (roll < push_pct)             return spq_pkg::OP_PUSH;
    if (roll < push_pct + pop_pct)   return spq_pkg::OP_POP;
    if (roll < 97)                   return spq_pkg::OP_DELETE;
    return spq_pkg::OP_CLEAR;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hit every error path of an empty queue.
  task automatic test_empty_queue();
    send_request(spq_pkg::OP_POP,    16'h1234, 8'h5A);
    send_request(spq_pkg::OP_DELETE, 16'h0000, 8'hA5);
    send_request(spq_pkg::OP_CLEAR,  16'hFFFF, 8'hFF);
  endtask

  // Fill to the brim with extremes, ties and a duplicated tag, then overflow.
  task automatic test_fill_to_full();
    logic [PrioBits-1:0] prios [16] = '{16'h8000, 16'h0000, 16'hFFFF, 16'h8000,
                                        16'h8000, 16'h5555, 16'hAAAA, 16'h0000,
                                        16'hFFFF, 16'h0001, 16'hFFFE, 16'h1234,
                                        16'h0100, 16'h7FFF, 16'h8001, 16'h0F0F};
    logic [TagBits-1:0]  tags  [16] = '{8'h01, 8'hFF, 8'h00, 8'h02,
                                        8'h03, 8'h55, 8'hAA, 8'h10,
                                        8'h11, 8'h20, 8'h21, 8'h20,
                                        8'h30, 8'h31, 8'h32, 8'h33};
    for (int i = 0; i < 16; i++) send_request(spq_pkg::OP_PUSH, prios[i], tags[i]);
    send_request(spq_pkg::OP_PUSH, 16'h0000, 8'h77);
  endtask

  // Delete the duplicated tag twice, miss once, pop twice, clear and pop the empty queue.
  task automatic test_delete_and_clear();
    send_request(spq_pkg::OP_DELETE, 16'hFFFF, 8'h20);
    send_request(spq_pkg::OP_DELETE, 16'h0000, 8'h20);
    send_request(spq_pkg::OP_DELETE, 16'h5555, 8'hC3);
    send_request(spq_pkg::OP_POP,    16'hAAAA, 8'h00);
    send_request(spq_pkg::OP_POP,    16'h0000, 8'hFF);
    send_request(spq_pkg::OP_CLEAR,  16'h0000, 8'h00);
    send_request(spq_pkg::OP_POP,    16'hFFFF, 8'hFF);
  endtask

  // Random traffic in modes that switch every few dozen requests. Deletes
  // mostly aim at a tag that is in the queue; the rest draw a random tag.
  task automatic test_random_traffic(int n_items, int unsigned s_idle, int unsigned r_idle);
    int           mode;
    int           left_in_mode;
    spq_pkg::op_e op;
    logic [TagBits-1:0] t;
    sender_idle_pct   = s_idle;
    receiver_idle_pct = r_idle;
    left_in_mode      = 0;
    mode              = 0;
    for (int n = 0; n < n_items; n++) begin
      if (left_in_mode == 0) begin
        mode         = $urandom_range(2);
        left_in_mode = $urandom_range(60, 30);
      end
      left_in_mode--;
      op = pick_op(mode);
      if (op == spq_pkg::OP_DELETE && held_count > 0 && $urandom_range(3) != 0)
        t = held_tag[$urandom_range(held_count - 1)];
      else
        t = pick_tag();
      send_request(op, pick_priority(), t);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    int waited;
    // Hold every input at a known value from time zero.
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    op_i              = spq_pkg::OP_PUSH;
    priority_req_i    = '0;
    tag_i             = '0;
    out_ready_i       = 1'b0;
    held_count        = 0;
    err_count         = 0;
    checked_count     = 0;
    sender_idle_pct   = 35;
    receiver_idle_pct = 56;
    foreach (op_count[i]) op_count[i] = 0;
    foreach (status_count[i]) status_count[i] = 0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_queue();
    test_fill_to_full();
    test_delete_and_clear();

    // Idle the sender more lightly than the receiver, then swap, then run flat out.
    test_random_traffic(300, 35, 56);
    test_random_traffic(300, 56, 35);
    test_random_traffic(300, 0, 0);

    // Drop valid and wait for every outstanding result.
    in_valid_i = 1'b0;
    waited = 0;
    while (expected_q.size() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      err_count++;
    end
    // Leave time for any stray extra result to show up.
    repeat (TailCycles) @(negedge clk_i);

    $display("requests: %0d push, %0d pop, %0d delete, %0d clear; %0d results checked",
             op_count[spq_pkg::OP_PUSH], op_count[spq_pkg::OP_POP],
             op_count[spq_pkg::OP_DELETE], op_count[spq_pkg::OP_CLEAR],
             checked_count);
    $display("status seen: ok %0d, empty %0d, full %0d, tag missing %0d",
             status_count[spq_pkg::ST_OK], status_count[spq_pkg::ST_EMPTY],
             status_count[spq_pkg::ST_FULL], status_count[spq_pkg::ST_NOTFOUND]);
    if (err_count == 0) begin
      $display("sorted_priority_queue_top: match");
    end else begin
      $display("sorted_priority_queue_top: mismatch");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(TimeoutNs);
    $display("timeout after %0d ns", TimeoutNs);
    $display("sorted_priority_queue_top: mismatch");
    $finish;
  end

endmodule
